// ===== rtl/core/rmsc_pkg.sv =====
// Package with shared types, widths and codes of the rms current unit.
package rmsc_pkg;

  // Fixed widths of registers, fields and the end-of-window datapath
  localparam int WIN_W      = 13;
  localparam int GAIN_W     = 32;
  localparam int SUM_W      = 48;
  localparam int ROOT_W     = SUM_W / 2;
  localparam int RMS_W      = 18;
  localparam int CUR_W      = 32;
  localparam int PROD_W     = RMS_W + GAIN_W;
  localparam int CUR_SHIFT  = 16;
  localparam int STEP_W     = $clog2(SUM_W);
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  // Fixed-point layout of the offset filter
  localparam int OFFSET_FRAC = 20;
  localparam int FILT_SHIFT  = 10;
  localparam int FILT_DROP   = 12;

  // Register reset values
  localparam logic [WIN_W-1:0]  WINDOW_RESET = 13'd1000;
  localparam logic [GAIN_W-1:0] GAIN_RESET   = 32'd503316;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_GAIN  = 4'd1;

  typedef enum logic [2:0] {
    S_ACC,
    S_DIV,
    S_SQRT,
    S_MUL,
    S_SAT
  } rmsc_state_t;

  typedef struct packed {
    logic              accept;
    logic              last;
    logic              div_load;
    logic              div_step;
    logic              sqrt_step;
    logic              mul;
    logic              out_load;
    logic [WIN_W-1:0]  win;
    logic [GAIN_W-1:0] gain;
  } rmsc_cmd_t;

  typedef struct packed {
    logic last_pending;
    logic last_commit;
    logic out_full;
  } rmsc_status_t;

endpackage

// ===== rtl/core/rmsc_ifs.sv =====
// Handshake interfaces for the sample, result and configuration channels.
interface rmsc_sample_if #(parameter int ADC_BITS = 10);
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] adc_sample;
  modport source (output valid, output adc_sample, input ready);
  modport sink (input valid, input adc_sample, output ready);
endinterface

interface rmsc_result_if;
  logic        valid;
  logic        ready;
  logic [17:0] rms_counts;
  logic [31:0] rms_current;
  modport source (output valid, output rms_counts, output rms_current, input ready);
  modport sink (input valid, input rms_counts, input rms_current, output ready);
endinterface

interface rmsc_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/rmsc_ctrl.sv =====
// Controller: registers, window counter and the end-of-window sequencer.
module rmsc_ctrl #(
  parameter int WINDOW_LOG2 = 12
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               sample_valid,
  output logic                               sample_ready,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rmsc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rmsc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  rmsc_pkg::rmsc_status_t             status,
  output rmsc_pkg::rmsc_cmd_t                cmd
);
  import rmsc_pkg::*;

  localparam int WIN_CAP_I = (WINDOW_LOG2 >= WIN_W) ? ((1 << WIN_W) - 1) : (1 << WINDOW_LOG2);
  localparam logic [WIN_W-1:0] WIN_CAP = WIN_CAP_I[WIN_W-1:0];
  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(SUM_W - 1);
  localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(ROOT_W - 1);

  logic [WIN_W-1:0]  window_length;
  logic [GAIN_W-1:0] current_gain;
  logic [WIN_W-1:0]  count, count_next;
  logic [STEP_W-1:0] step, step_next;
  rmsc_state_t       state, state_next;

  logic [WIN_W-1:0] win;
  logic [WIN_W-1:0] count_inc;
  logic             win_done;

  // Write configuration registers; the port never stalls
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_RESET;
      current_gain  <= GAIN_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WINDOW_LENGTH: window_length <= cfg_data[WIN_W-1:0];
        CFG_CURRENT_GAIN:  current_gain  <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the window to its legal range
  always_comb begin
    if (window_length == '0) begin
      win = WIN_W'(1);
    end else if (window_length > WIN_CAP) begin
      win = WIN_CAP;
    end else begin
      win = window_length;
    end
  end

  assign count_inc = count + 1'b1;
  assign win_done  = (count_inc >= win);

  // Hold off a window-closing word while the previous result still waits
  assign sample_ready = (state == S_ACC) && !status.last_pending &&
                        !(win_done && status.out_full);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACC;
      count <= '0;
      step  <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      step  <= step_next;
    end
  end

  // Sequence accumulate, divide, root, multiply and saturate
  always_comb begin
    state_next    = state;
    count_next    = count;
    step_next     = step;
    cmd.accept    = 1'b0;
    cmd.last      = 1'b0;
    cmd.div_load  = 1'b0;
    cmd.div_step  = 1'b0;
    cmd.sqrt_step = 1'b0;
    cmd.mul       = 1'b0;
    cmd.out_load  = 1'b0;
    cmd.win       = win;
    cmd.gain      = current_gain;
    case (state)
      S_ACC: begin
        if (sample_valid && sample_ready) begin
          cmd.accept = 1'b1;
          cmd.last   = win_done;
          count_next = win_done ? '0 : count_inc;
        end
        if (status.last_commit) begin
          cmd.div_load = 1'b1;
          step_next    = '0;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step == DIV_LAST) begin
          step_next  = '0;
          state_next = S_SQRT;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (step == SQRT_LAST) begin
          step_next  = '0;
          state_next = S_MUL;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_SAT;
      end
      S_SAT: begin
        cmd.out_load = 1'b1;
        state_next   = S_ACC;
      end
      default: begin
        state_next = S_ACC;
      end
    endcase
  end

endmodule

// ===== rtl/core/rmsc_datapath.sv =====
// Datapath: offset filter, square-and-sum pipeline, divider, root, scaling.
module rmsc_datapath #(
  parameter int ADC_BITS = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [ADC_BITS-1:0]            adc_sample,
  input  rmsc_pkg::rmsc_cmd_t            cmd,
  output rmsc_pkg::rmsc_status_t         status,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rmsc_pkg::RMS_W-1:0]     rms_counts,
  output logic [rmsc_pkg::CUR_W-1:0]     rms_current
);
  import rmsc_pkg::*;

  localparam int OFF_W  = ADC_BITS + OFFSET_FRAC;
  localparam int D_W    = OFF_W + 1;
  localparam int FILT_W = D_W - FILT_DROP;
  localparam int SQ_W   = 2 * FILT_W - 1;
  localparam int ACC_W  = ((SQ_W > SUM_W) ? SQ_W : SUM_W) + 1;
  localparam logic [ACC_W-1:0] SUM_MAX = ACC_W'({SUM_W{1'b1}});

  // Pipeline registers
  logic [OFF_W-1:0]         offset_estimate;
  logic signed [D_W-1:0]    diff_a;
  logic signed [FILT_W-1:0] filt_b;
  logic [SQ_W-1:0]          sq_c;
  logic                     va, vb, vc, la, lb, lc;
  logic [SUM_W-1:0]         square_sum;

  // End-of-window registers
  logic [SUM_W-1:0]  dq;
  logic [WIN_W-1:0]  drem;
  logic [WIN_W-1:0]  dwin;
  logic [ROOT_W+1:0] srem;
  logic [ROOT_W-1:0] root;
  logic [PROD_W-1:0] prod;

  logic signed [D_W-1:0]      diff, off_sum, filt_full;
  logic signed [2*FILT_W-1:0] sq_full;
  logic [ACC_W-1:0]           sum_add;
  logic [SUM_W-1:0]           sum_sat;
  logic [WIN_W:0]             div_sh;
  logic                       div_ge;
  logic [WIN_W:0]             div_sub;
  logic [ROOT_W+3:0]          sq_sh, sq_trial, sq_sub;
  logic                       sq_ge;

  // Update the offset and form the raw difference
  assign diff    = $signed({1'b0, adc_sample, {OFFSET_FRAC{1'b0}}}) -
                   $signed({1'b0, offset_estimate});
  assign off_sum = $signed({1'b0, offset_estimate}) + (diff >>> FILT_SHIFT);

  // Difference to the updated offset, then square
  assign filt_full = diff_a - (diff_a >>> FILT_SHIFT);
  assign sq_full   = filt_b * filt_b;

  // Accumulate with saturation at the sum's maximum
  assign sum_add = ACC_W'(square_sum) + ACC_W'(sq_c);
  assign sum_sat = (sum_add > SUM_MAX) ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];

  // One restoring divide step
  assign div_sh  = {drem, dq[SUM_W-1]};
  assign div_ge  = (div_sh >= {1'b0, dwin});
  assign div_sub = div_sh - {1'b0, dwin};

  // One digit of the square root
  assign sq_sh    = {srem, dq[SUM_W-1:SUM_W-2]};
  assign sq_trial = {2'b00, root, 2'b01};
  assign sq_ge    = (sq_sh >= sq_trial);
  assign sq_sub   = sq_sh - sq_trial;

  assign status.last_pending = (va && la) || (vb && lb) || (vc && lc);
  assign status.last_commit  = vc && lc;
  assign status.out_full     = out_valid;

  // Advance the valid flags, update the offset, and clear or accumulate the sum
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      offset_estimate <= '0;
      square_sum      <= '0;
    end else begin
      va <= cmd.accept;
      vb <= va;
      vc <= vb;
      if (cmd.accept) begin
        offset_estimate <= off_sum[OFF_W-1:0];
      end
      if (cmd.div_load) begin
        square_sum <= '0;
      end else if (vc) begin
        square_sum <= sum_sat;
      end
    end
  end

  // Payload of the sample pipeline
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      diff_a <= diff;
      la     <= cmd.last;
    end
    filt_b <= filt_full[D_W-1:FILT_DROP];
    lb     <= la;
    sq_c   <= sq_full[SQ_W-1:0];
    lc     <= lb;
  end

  // Divide, then take the root in the same shift register, then scale by the gain
  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      dq   <= sum_sat;
      drem <= '0;
      dwin <= cmd.win;
      srem <= '0;
      root <= '0;
    end else if (cmd.div_step) begin
      drem <= div_ge ? div_sub[WIN_W-1:0] : div_sh[WIN_W-1:0];
      dq   <= {dq[SUM_W-2:0], div_ge};
    end else if (cmd.sqrt_step) begin
      srem <= sq_ge ? sq_sub[ROOT_W+1:0] : sq_sh[ROOT_W+1:0];
      root <= {root[ROOT_W-2:0], sq_ge};
      dq   <= {dq[SUM_W-3:0], 2'b00};
    end
    if (cmd.mul) begin
      prod <= root[RMS_W-1:0] * cmd.gain;
    end
  end

  // Output register: load a result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rms_counts  <= root[RMS_W-1:0];
      rms_current <= (|prod[PROD_W-1:CUR_W+CUR_SHIFT]) ? {CUR_W{1'b1}}
                                                     : prod[CUR_W+CUR_SHIFT-1:CUR_SHIFT];
    end
  end

endmodule

// ===== rtl/core/rms_current_with_offset_tracking_unit.sv =====
// Top level of the true-rms current meter with tracked DC offset.
// Throughput: one sample word per cycle inside a window, but a closing word
// waits while the previous result is held. The closing word's result follows
// 3 pipeline stages, 48 restoring divide steps, 24 root steps, multiply and
// saturate; the sample port stalls meanwhile, the configuration port never.
// Reset: synchronous; clears offset, sum and count, restores registers, no sweep.
module rms_current_with_offset_tracking_unit #(
  parameter int ADC_BITS    = 10,
  parameter int WINDOW_LOG2 = 12
) (
  input  logic          clk,
  input  logic          rst,
  rmsc_sample_if.sink   sample,
  rmsc_result_if.source result,
  rmsc_cfg_if.sink      cfg
);
  import rmsc_pkg::*;

  rmsc_cmd_t    cmd;
  rmsc_status_t status;

  rmsc_ctrl #(
    .WINDOW_LOG2(WINDOW_LOG2)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample.valid),
    .sample_ready (sample.ready),
    .cfg_valid    (cfg.valid),
    .cfg_ready    (cfg.ready),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .status       (status),
    .cmd          (cmd)
  );

  rmsc_datapath #(
    .ADC_BITS(ADC_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .adc_sample  (sample.adc_sample),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .rms_counts  (result.rms_counts),
    .rms_current (result.rms_current)
  );

endmodule

// ===== rtl/core/rmsc_checker.sv =====
// Port-level assertions for the rms current unit and their bind.
module rmsc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [17:0] rms_counts,
  input logic [31:0] rms_current
);

  // A stalled result word holds its valid and payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(rms_counts) && $stable(rms_current))
    else $error("result word changed while stalled");

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // A fresh result never follows a sample word in the cycle before
  a_result_gap: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result appeared directly after a sample word");

  // Zero rms gives zero current
  a_zero_current: assert property (@(posedge clk) disable iff (rst)
    out_valid && (rms_counts == 18'd0) |-> (rms_current == 32'd0))
    else $error("nonzero current for zero rms");

endmodule

bind rms_current_with_offset_tracking_unit rmsc_checker u_rmsc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (sample.valid),
  .in_ready    (sample.ready),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .rms_counts  (result.rms_counts),
  .rms_current (result.rms_current)
);
